FILE: sv/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and round tables
// Holds the item codes, the queue entry, the sequencer states and the MD5
// round constants, shift amounts and message word schedule.
// ----------------------------------------------------------------------------
package md5_pkg;

  // Initial chaining words.
  localparam logic [31:0] INIT_A = 32'h6745_2301;
  localparam logic [31:0] INIT_B = 32'hEFCD_AB89;
  localparam logic [31:0] INIT_C = 32'h98BA_DCFE;
  localparam logic [31:0] INIT_D = 32'h1032_5476;

  // Padding marker and block positions.
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [6:0] LEN_POS   = 7'd56;
  localparam logic [6:0] BLOCK_END = 7'd64;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);

  // Input commands.
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Classified operations handed to the back.
  typedef enum logic [1:0] {
    OP_DATA,
    OP_DATA_LAST,
    OP_FINISH
  } op_t;

  // One queue entry: for data the low byte of data holds the message byte,
  // for a finish it holds the message length in bits.
  typedef struct packed {
    op_t         op;
    logic [5:0]  pos;
    logic [63:0] data;
  } q_entry_t;

  // Back sequencer states.
  typedef enum logic [2:0] {
    ST_ABSORB,
    ST_PAD,
    ST_START,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Rotate amount for a round.
  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'h0:    s = 5'd7;
      4'h1:    s = 5'd12;
      4'h2:    s = 5'd17;
      4'h3:    s = 5'd22;
      4'h4:    s = 5'd5;
      4'h5:    s = 5'd9;
      4'h6:    s = 5'd14;
      4'h7:    s = 5'd20;
      4'h8:    s = 5'd4;
      4'h9:    s = 5'd11;
      4'hA:    s = 5'd16;
      4'hB:    s = 5'd23;
      4'hC:    s = 5'd6;
      4'hD:    s = 5'd10;
      4'hE:    s = 5'd15;
      4'hF:    s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used in a round.
  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] g;
    i = r[3:0];
    case (r[5:4])
      2'd0:    g = i;
      2'd1:    g = (i << 2) + i + 4'd1;
      2'd2:    g = (i << 1) + i + 4'd5;
      default: g = (i << 3) - i;
    endcase
    return g;
  endfunction

  // Additive constant for a round.
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

FILE: sv/md5_if.sv
// ----------------------------------------------------------------------------
// md5_if: stream channels of the MD5 hasher
// Valid/ready channels for message bytes and commands in and digest words out.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source  (output valid, command, data_byte, input ready);
  modport sink    (input valid, command, data_byte, output ready);
  modport monitor (input valid, ready, command, data_byte);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source  (output valid, digest_word, word_index, last_word, input ready);
  modport sink    (input valid, digest_word, word_index, last_word, output ready);
  modport monitor (input valid, ready, digest_word, word_index, last_word);
endinterface

FILE: sv/md5_queue.sv
// ----------------------------------------------------------------------------
// md5_queue: short queue between front and back
// Holds classified words so that the front can accept up to two of them while
// the back is busy with a compression.
// ----------------------------------------------------------------------------
module md5_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  md5_pkg::q_entry_t push_entry,
  input  logic              pop,
  output md5_pkg::q_entry_t head,
  output logic              empty,
  output logic              full
);

  md5_pkg::q_entry_t       mem_r [md5_pkg::QUEUE_DEPTH];
  logic [md5_pkg::Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [md5_pkg::Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [md5_pkg::Q_AW:0]   count_r, count_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (md5_pkg::Q_AW+1)'(md5_pkg::QUEUE_DEPTH));
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: sv/md5_front.sv
// ----------------------------------------------------------------------------
// md5_front: input acceptance and classification
// Keeps the block position and the message length, tags each word as a
// data byte, the byte that completes a block, or a finish carrying the
// bit length, and pushes it into the queue.
// ----------------------------------------------------------------------------
module md5_front (
  input  logic              clk,
  input  logic              rst_n,
  md5_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              q_push,
  output md5_pkg::q_entry_t q_entry
);

  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] msg_r, msg_nxt;
  logic        accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign q_push        = accept;

  // Classify the word and advance the counters.
  always_comb begin
    fill_nxt      = fill_r;
    msg_nxt       = msg_r;
    q_entry.pos   = fill_r;
    q_entry.op    = md5_pkg::OP_DATA;
    q_entry.data  = {56'd0, in_chan.data_byte};
    if (in_chan.command == md5_pkg::CMD_FINISH) begin
      q_entry.op   = md5_pkg::OP_FINISH;
      q_entry.data = {msg_r, 3'b000};
      if (accept) begin
        fill_nxt = '0;
        msg_nxt  = '0;
      end
    end else begin
      if (fill_r == 6'd63) begin
        q_entry.op = md5_pkg::OP_DATA_LAST;
      end
      if (accept) begin
        fill_nxt = fill_r + 6'd1;
        msg_nxt  = msg_r + 61'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      msg_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      msg_r  <= msg_nxt;
    end
  end

endmodule

FILE: sv/md5_back.sv
// ----------------------------------------------------------------------------
// md5_back: block buffer, padding, compression and digest output
// Writes bytes into the 16-word block, pads on finish, runs one MD5 round
// per cycle and drains the digest through a four-word output register.
// ----------------------------------------------------------------------------
module md5_back (
  input  logic              clk,
  input  logic              rst_n,
  input  md5_pkg::q_entry_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  md5_out_if.source         out_chan
);

  md5_pkg::state_t state_r, state_nxt;
  md5_pkg::state_t ret_r, ret_nxt;
  logic [6:0]  ptr_r, ptr_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] chain_r [4];
  logic [31:0] chain_nxt [4];
  logic [31:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [31:0] pre_r, pre_nxt;
  logic [31:0] obuf_r [4];
  logic [31:0] obuf_nxt [4];
  logic [1:0]  ocnt_r, ocnt_nxt;
  logic        obusy_r, obusy_nxt;

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot_w;
  logic [31:0] rot;
  logic [5:0]  rnd_inc;
  logic        out_fire;

  function automatic logic [5:0] round_s_amt(input logic [5:0] r);
    return {1'b0, md5_pkg::round_s(r)};
  endfunction

  // Round function of the current round group.
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end

  // The a + K + W part is summed one round ahead into pre_r.
  assign sum     = pre_r + f;
  assign rot_w   = {sum, sum} << round_s_amt(rnd_r);
  assign rot     = rot_w[63:32];
  assign rnd_inc = rnd_r + 6'd1;

  // Digest output register.
  assign out_chan.valid       = obusy_r;
  assign out_chan.digest_word = obuf_r[0];
  assign out_chan.word_index  = ocnt_r;
  assign out_chan.last_word   = (ocnt_r == 2'd3);
  assign out_fire             = obusy_r && out_chan.ready;

  assign q_pop = (state_r == md5_pkg::ST_ABSORB) && !q_empty;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ptr_nxt   = ptr_r;
    rnd_nxt   = rnd_r;
    len_nxt   = len_r;
    w_nxt     = w_r;
    chain_nxt = chain_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    pre_nxt   = pre_r;
    obuf_nxt  = obuf_r;
    ocnt_nxt  = ocnt_r;
    obusy_nxt = obusy_r;

    // Shift out one digest word per handshake.
    if (out_fire) begin
      obuf_nxt[0] = obuf_r[1];
      obuf_nxt[1] = obuf_r[2];
      obuf_nxt[2] = obuf_r[3];
      ocnt_nxt    = ocnt_r + 2'd1;
      if (ocnt_r == 2'd3) begin
        obusy_nxt = 1'b0;
      end
    end

    case (state_r)
      md5_pkg::ST_ABSORB: begin
        if (!q_empty) begin
          case (q_head.op)
            md5_pkg::OP_DATA: begin
              w_nxt[q_head.pos[5:2]][{q_head.pos[1:0], 3'b000} +: 8] = q_head.data[7:0];
            end
            md5_pkg::OP_DATA_LAST: begin
              w_nxt[q_head.pos[5:2]][{q_head.pos[1:0], 3'b000} +: 8] = q_head.data[7:0];
              ret_nxt   = md5_pkg::ST_ABSORB;
              state_nxt = md5_pkg::ST_START;
            end
            default: begin
              w_nxt[q_head.pos[5:2]][{q_head.pos[1:0], 3'b000} +: 8] = md5_pkg::PAD_BYTE;
              ptr_nxt   = {1'b0, q_head.pos} + 7'd1;
              len_nxt   = q_head.data;
              state_nxt = md5_pkg::ST_PAD;
            end
          endcase
        end
      end

      md5_pkg::ST_PAD: begin
        if (ptr_r == md5_pkg::BLOCK_END) begin
          // Length does not fit: compress this block and pad a fresh one.
          ptr_nxt   = '0;
          ret_nxt   = md5_pkg::ST_PAD;
          state_nxt = md5_pkg::ST_START;
        end else if (ptr_r == md5_pkg::LEN_POS) begin
          w_nxt[14] = len_r[31:0];
          w_nxt[15] = len_r[63:32];
          ret_nxt   = md5_pkg::ST_OUT;
          state_nxt = md5_pkg::ST_START;
        end else begin
          w_nxt[ptr_r[5:2]][{ptr_r[1:0], 3'b000} +: 8] = 8'h00;
          ptr_nxt = ptr_r + 7'd1;
        end
      end

      md5_pkg::ST_START: begin
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        pre_nxt   = chain_r[0] + md5_pkg::round_k(6'd0) + w_r[md5_pkg::msg_idx(6'd0)];
        rnd_nxt   = '0;
        state_nxt = md5_pkg::ST_ROUND;
      end

      md5_pkg::ST_ROUND: begin
        a_nxt   = d_r;
        b_nxt   = b_r + rot;
        c_nxt   = b_r;
        d_nxt   = c_r;
        pre_nxt = d_r + md5_pkg::round_k(rnd_inc) + w_r[md5_pkg::msg_idx(rnd_inc)];
        rnd_nxt = rnd_inc;
        if (rnd_r == 6'd63) begin
          state_nxt = md5_pkg::ST_ADD;
        end
      end

      md5_pkg::ST_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        state_nxt    = ret_r;
      end

      md5_pkg::ST_OUT: begin
        // Wait until the previous digest has fully drained.
        if (!obusy_r) begin
          obuf_nxt     = chain_r;
          ocnt_nxt     = '0;
          obusy_nxt    = 1'b1;
          chain_nxt[0] = md5_pkg::INIT_A;
          chain_nxt[1] = md5_pkg::INIT_B;
          chain_nxt[2] = md5_pkg::INIT_C;
          chain_nxt[3] = md5_pkg::INIT_D;
          state_nxt    = md5_pkg::ST_ABSORB;
        end
      end

      default: begin
        state_nxt = md5_pkg::ST_ABSORB;
      end
    endcase
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= md5_pkg::ST_ABSORB;
      ret_r      <= md5_pkg::ST_ABSORB;
      ptr_r      <= '0;
      rnd_r      <= '0;
      ocnt_r     <= '0;
      obusy_r    <= 1'b0;
      chain_r[0] <= md5_pkg::INIT_A;
      chain_r[1] <= md5_pkg::INIT_B;
      chain_r[2] <= md5_pkg::INIT_C;
      chain_r[3] <= md5_pkg::INIT_D;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ptr_r   <= ptr_nxt;
      rnd_r   <= rnd_nxt;
      ocnt_r  <= ocnt_nxt;
      obusy_r <= obusy_nxt;
      chain_r <= chain_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    w_r    <= w_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    pre_r  <= pre_nxt;
    obuf_r <= obuf_nxt;
  end

endmodule

FILE: sv/md5_stream_hash.sv
// A data byte is accepted whenever the queue has room; the byte that completes
// a block holds the back for a compression (load, 64 rounds, chaining add).
// During a compression bytes are taken only until both queue entries are full.
// Finish: byte-wise padding plus one or two compressions,
// then four digest words, one per cycle while the sink is ready.
// Reset (synchronous, active low) restores the MD5 initial chaining words
// and clears the counters and queue; the block buffer is not cleared.
// ----------------------------------------------------------------------------
// md5_stream_hash: streaming MD5 hasher
// Front classifies incoming words, a short queue decouples it from the back,
// which pads, compresses and emits the digest.
// ----------------------------------------------------------------------------
module md5_stream_hash (
  input  logic      clk,
  input  logic      rst_n,
  md5_in_if.sink    in_chan,
  md5_out_if.source out_chan
);

  md5_pkg::q_entry_t push_entry;
  md5_pkg::q_entry_t head;
  logic              push;
  logic              pop;
  logic              q_empty;
  logic              q_full;

  // Front: accept and classify.
  md5_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (push),
    .q_entry (push_entry)
  );

  // Queue between front and back.
  md5_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // Back: pad, compress and emit.
  md5_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (head),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

endmodule

FILE: sv/md5_stream_hash_chk.sv
// ----------------------------------------------------------------------------
// md5_stream_hash_chk: port-level checks of the MD5 hasher
// Watches the digest channel for word ordering and stall behaviour, and the input channel for known commands.
// ----------------------------------------------------------------------------
module md5_stream_hash_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [1:0]  out_word_index,
  input logic        out_last_word
);

  logic out_fire;

  assign out_fire = out_valid && out_ready;

  // The last-word flag marks exactly the fourth digest word.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 2'd3)))
    else $error("last_word does not match word_index");

  // Digest words follow one another without a gap.
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 2'd1))
    else $error("digest word sequence broken");

  // A new digest always starts with word A.
  a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_last_word) |=> (!out_valid || out_word_index == 2'd0))
    else $error("digest does not start at word A");

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_word_index)))
    else $error("stalled digest word changed");

  // An accepted input word carries a known command.
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !$isunknown(in_command))
    else $error("command unknown on an accepted word");

endmodule

bind md5_stream_hash md5_stream_hash_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_command      (in_chan.command),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_digest_word (out_chan.digest_word),
  .out_word_index  (out_chan.word_index),
  .out_last_word   (out_chan.last_word)
);
